[src/sm83_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU package
// Shared types, constants and operation classes for the SM83 ALU unit.
// ----------------------------------------------------------------------------
package sm83_pkg;

  localparam int unsigned QueueDepth = 2;

  // Operation class chosen by the front end.
  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_INC,
    CLS_DEC,
    CLS_ACC,
    CLS_ALU,
    CLS_CB
  } op_class_e;

  // One decoded word handed from the front end to the back end.
  typedef struct packed {
    op_class_e  cls;
    logic [2:0] sel;
    logic [1:0] grp;
    logic [7:0] accum;
    logic [7:0] operand;
    logic [3:0] flags;
  } dec_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       write_enable;
    logic       handled;
  } res_word_t;

  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [3:0] DaaLoLimit = 4'h9;

  // Rotate and shift group, shared by the CB page and the accumulator rotates.
  function automatic logic [8:0] shift_op(input logic [2:0] sel, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] r;
    begin
      case (sel)
        3'd0:    r = {v[7], v[6:0], v[7]};
        3'd1:    r = {v[0], v[0], v[7:1]};
        3'd2:    r = {v[7], v[6:0], cin};
        3'd3:    r = {v[0], cin, v[7:1]};
        3'd4:    r = {v[7], v[6:0], 1'b0};
        3'd5:    r = {v[0], v[7], v[7:1]};
        3'd6:    r = {1'b0, v[3:0], v[7:4]};
        default: r = {v[0], 1'b0, v[7:1]};
      endcase
      return r;
    end
  endfunction

endpackage

[src/sm83_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU channels
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface sm83_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] opcode;
  logic [7:0] accum;
  logic [7:0] operand;
  logic [3:0] flags_in;

  modport source (output valid, req_type, opcode, accum, operand, flags_in, input ready);
  modport sink   (input valid, req_type, opcode, accum, operand, flags_in, output ready);
endinterface

interface sm83_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic [3:0] flags_out;
  logic       write_enable;
  logic       handled;

  modport source (output valid, result, flags_out, write_enable, handled, input ready);
  modport sink   (input valid, result, flags_out, write_enable, handled, output ready);
endinterface

[src/sm83_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU front end
// Accepts request words, classifies the opcode and registers the decoded word.
// ----------------------------------------------------------------------------
module sm83_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sm83_req_if.sink            req,
  output logic                dec_valid_o,
  input  logic                dec_ready_i,
  output sm83_pkg::dec_word_t dec_word_o
);
  import sm83_pkg::*;

  logic      valid_q;
  dec_word_t word_q, word_d;
  op_class_e cls;

  assign req.ready = !valid_q || dec_ready_i;

  // Opcode classification.
  always_comb begin
    if (req.req_type) begin
      cls = CLS_CB;
    end else if ((req.opcode & 8'hc7) == 8'h04) begin
      cls = CLS_INC;
    end else if ((req.opcode & 8'hc7) == 8'h05) begin
      cls = CLS_DEC;
    end else if ((req.opcode & 8'hc7) == 8'h07) begin
      cls = CLS_ACC;
    end else if (req.opcode[7:6] == 2'b10 || (req.opcode & 8'hc7) == 8'hc6) begin
      cls = CLS_ALU;
    end else begin
      cls = CLS_NONE;
    end
    word_d = '{cls: cls, sel: req.opcode[5:3], grp: req.opcode[7:6],
               accum: req.accum, operand: req.operand, flags: req.flags_in};
  end

  // Decoded word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req.ready) begin
      valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      word_q <= word_d;
    end
  end

  assign dec_valid_o = valid_q;
  assign dec_word_o  = word_q;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !dec_ready_i |=> valid_q && $stable(word_q))
    else $error("decoded word changed while stalled");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> valid_q)
    else $error("accepted word lost");
  a_cb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready && req.req_type |=> word_q.cls == CLS_CB)
    else $error("CB page misclassified");
`endif
endmodule

[src/sm83_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU decoupling queue
// Short FIFO of decoded words between front end and back end.
// ----------------------------------------------------------------------------
module sm83_queue #(
  parameter int unsigned Depth = sm83_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sm83_pkg::dec_word_t in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sm83_pkg::dec_word_t out_word_o
);
  import sm83_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);

  dec_word_t       mem_q [Depth];
  logic [Aw-1:0]   wr_q, rd_q;
  logic [Cw-1:0]   cnt_q;
  logic            push, pop;

  assign in_ready_o  = cnt_q != Cw'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign out_word_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + Cw'(push) - Cw'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_word_i;
    end
  end

`ifndef SYNTH
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Cw'(Depth))
    else $error("queue overfilled");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count wrong");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push && cnt_q == Cw'(1) |=> !out_valid_o)
    else $error("queue not empty after last pop");
`endif
endmodule

[src/sm83_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU back end
// Executes decoded words and holds results in an output register.
// ----------------------------------------------------------------------------
module sm83_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                dec_valid_i,
  output logic                dec_ready_o,
  input  sm83_pkg::dec_word_t dec_word_i,
  sm83_rsp_if.source          rsp
);
  import sm83_pkg::*;

  logic      valid_q;
  res_word_t res_q, res_d;

  logic [7:0] a, v, r8, off;
  logic [3:0] f;
  logic [8:0] sh, sum;
  logic [4:0] hs;
  logic       cin, c, h, n, we, z;

  assign dec_ready_o = !valid_q || rsp.ready;

  // Execution of one decoded word.
  always_comb begin
    a   = dec_word_i.accum;
    v   = dec_word_i.operand;
    f   = dec_word_i.flags;
    cin = f[0];
    sh  = shift_op(dec_word_i.sel, (dec_word_i.cls == CLS_CB) ? v : a, cin);
    r8  = '0;
    off = '0;
    sum = '0;
    hs  = '0;
    c = 1'b0; h = 1'b0; n = 1'b0; we = 1'b0; z = 1'b0;
    res_d = '{result: 8'h00, flags_out: f, write_enable: 1'b0, handled: 1'b0};
    unique case (dec_word_i.cls)
      CLS_CB: begin
        res_d.handled = 1'b1;
        case (dec_word_i.grp)
          2'd0: begin
            res_d.result = sh[7:0];
            res_d.flags_out = {sh[7:0] == 8'h00, 2'b00, sh[8]};
            res_d.write_enable = 1'b1;
          end
          2'd1: res_d.flags_out = {~v[dec_word_i.sel], 2'b01, cin};
          2'd2: begin
            res_d.result = v & ~(8'h01 << dec_word_i.sel);
            res_d.write_enable = 1'b1;
          end
          default: begin
            res_d.result = v | (8'h01 << dec_word_i.sel);
            res_d.write_enable = 1'b1;
          end
        endcase
      end
      CLS_INC: begin
        r8 = v + 8'd1;
        res_d = '{result: r8, flags_out: {r8 == 8'h00, 1'b0, v[3:0] == 4'hf, cin},
                  write_enable: 1'b1, handled: 1'b1};
      end
      CLS_DEC: begin
        r8 = v - 8'd1;
        res_d = '{result: r8, flags_out: {r8 == 8'h00, 1'b1, v[3:0] == 4'h0, cin},
                  write_enable: 1'b1, handled: 1'b1};
      end
      CLS_ACC: begin
        res_d.handled = 1'b1;
        res_d.write_enable = 1'b1;
        case (dec_word_i.sel)
          3'd0, 3'd1, 3'd2, 3'd3: begin
            res_d.result = sh[7:0];
            res_d.flags_out = {3'b000, sh[8]};
          end
          3'd4: begin
            c = cin;
            if (f[1] || (!f[2] && a[3:0] > DaaLoLimit)) off = off | DaaLoAdj;
            if (cin || (!f[2] && a > DaaHiLimit)) begin
              off = off | DaaHiAdj;
              c = 1'b1;
            end
            r8 = f[2] ? a - off : a + off;
            res_d.result = r8;
            res_d.flags_out = {r8 == 8'h00, f[2], 1'b0, c};
          end
          3'd5: begin
            res_d.result = ~a;
            res_d.flags_out = {f[3], 2'b11, cin};
          end
          3'd6: begin
            res_d.result = a;
            res_d.flags_out = {f[3], 3'b001};
          end
          default: begin
            res_d.result = a;
            res_d.flags_out = {f[3], 2'b00, ~cin};
          end
        endcase
      end
      CLS_ALU: begin
        we = 1'b1;
        case (dec_word_i.sel)
          3'd0, 3'd1: begin
            c   = dec_word_i.sel[0] & cin;
            sum = {1'b0, a} + {1'b0, v} + {8'h00, c};
            hs  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, c};
            r8  = sum[7:0]; h = hs[4]; c = sum[8];
          end
          3'd2, 3'd3, 3'd7: begin
            c   = (dec_word_i.sel == 3'd3) & cin;
            sum = {1'b0, a} - {1'b0, v} - {8'h00, c};
            hs  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, c};
            r8  = sum[7:0]; h = hs[4]; c = sum[8]; n = 1'b1;
            we  = dec_word_i.sel != 3'd7;
          end
          3'd4: begin
            r8 = a & v; h = 1'b1; c = 1'b0;
          end
          3'd5: begin
            r8 = a ^ v; c = 1'b0;
          end
          default: begin
            r8 = a | v; c = 1'b0;
          end
        endcase
        z = r8 == 8'h00;
        res_d = '{result: we ? r8 : 8'h00, flags_out: {z, n, h, c},
                  write_enable: we, handled: 1'b1};
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (dec_ready_o) begin
      valid_q <= dec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_ready_o && dec_valid_i) begin
      res_q <= res_d;
    end
  end

  assign rsp.valid        = valid_q;
  assign rsp.result       = res_q.result;
  assign rsp.flags_out    = res_q.flags_out;
  assign rsp.write_enable = res_q.write_enable;
  assign rsp.handled      = res_q.handled;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !rsp.ready |=> valid_q && $stable(res_q))
    else $error("result changed while stalled");
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.write_enable |-> res_q.handled)
    else $error("write enable on an unhandled opcode");
  a_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.write_enable |-> res_q.result == 8'h00)
    else $error("result not cleared without write");
`endif
endmodule

[src/sm83_alu_with_flags_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU with flags
// 8-bit ALU of the SM83 CPU: result byte, new Z/N/H/C flags, write enable.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while no stall holds it. There are three register
// stages. The front end registers the decoded word when it accepts it. The word
// is then written into a two-entry queue, and the back end computes and
// registers the result from the queue head. Both sides stall independently; no
// reset clearing is needed.
module sm83_alu_with_flags_unit #(
  parameter int unsigned QueueDepth = sm83_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sm83_req_if.sink   req,
  sm83_rsp_if.source rsp
);
  import sm83_pkg::*;

  logic      f_valid, f_ready, b_valid, b_ready;
  dec_word_t f_word, b_word;

  sm83_front u_front (
    .clk_i, .rst_ni, .req,
    .dec_valid_o(f_valid), .dec_ready_i(f_ready), .dec_word_o(f_word)
  );

  sm83_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_word_i(f_word),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_word_o(b_word)
  );

  sm83_back u_back (
    .clk_i, .rst_ni,
    .dec_valid_i(b_valid), .dec_ready_o(b_ready), .dec_word_i(b_word), .rsp
  );
endmodule

[dv/tb_sm83_alu_with_flags_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU with flags testbench
// Drives request words over the valid/ready request channel and compares every
// result word against an in-bench computation of the SM83 ALU. Covers directed
// corner cases, then random words on both opcode pages, with random stalls and
// one long result hold-off.
// ----------------------------------------------------------------------------
module tb_sm83_alu_with_flags_unit;

  typedef struct packed {
    logic       req_type;
    logic [7:0] opcode;
    logic [7:0] accum;
    logic [7:0] operand;
    logic [3:0] flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       write_enable;
    logic       handled;
  } alu_rsp_t;

  localparam logic       PAGE_MAIN = 1'b0;
  localparam logic       PAGE_CB   = 1'b1;
  localparam logic [7:0] OP_DAA    = 8'h27;
  localparam logic [7:0] OP_CPL    = 8'h2f;
  localparam logic [7:0] OP_SCF    = 8'h37;
  localparam logic [7:0] OP_CCF    = 8'h3f;
  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_ADD_B  = 8'h80;
  localparam logic [7:0] OP_CP_N   = 8'hfe;

  logic clk_i;
  logic rst_ni;

  sm83_req_if req ();
  sm83_rsp_if rsp ();

  sm83_alu_with_flags_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source)
  );

  alu_req_t pending_words[$];
  alu_rsp_t expected_words[$];
  int       mismatches;
  int       words_checked;
  int       cb_words;
  bit       quiet_phase;
  bit       hold_rsp;
  int       req_gap;
  int       rsp_gap;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Eight accumulator operations, selected by opcode bits 5:3.
  function automatic alu_rsp_t calc_acc_op(logic [2:0] sel, logic [7:0] a, logic [7:0] b,
                                           logic [3:0] f);
    alu_rsp_t   o;
    logic [9:0] wide;
    logic       n, h, c, cin;
    cin  = f[0];
    n    = 1'b0;
    h    = 1'b0;
    c    = 1'b0;
    wide = '0;
    o.write_enable = 1'b1;
    o.handled      = 1'b1;
    case (sel)
      3'd0: begin
        wide = {2'b00, a} + {2'b00, b};
        h    = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'h0f;
        c    = wide[8];
      end
      3'd1: begin
        wide = {2'b00, a} + {2'b00, b} + {9'h000, cin};
        h    = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin}) > 5'h0f;
        c    = wide[8];
      end
      3'd2, 3'd7: begin
        wide = {2'b00, a} - {2'b00, b};
        n    = 1'b1;
        h    = b[3:0] > a[3:0];
        c    = b > a;
        if (sel == 3'd7) o.write_enable = 1'b0;
      end
      3'd3: begin
        wide = {2'b00, a} - {2'b00, b} - {9'h000, cin};
        n    = 1'b1;
        h    = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, cin});
        c    = {1'b0, a} < ({1'b0, b} + {8'h00, cin});
      end
      3'd4: begin
        wide = {2'b00, a & b};
        h    = 1'b1;
      end
      3'd5: wide = {2'b00, a ^ b};
      default: wide = {2'b00, a | b};
    endcase
    o.flags_out = {wide[7:0] == 8'h00, n, h, c};
    o.result    = o.write_enable ? wide[7:0] : 8'h00;
    return o;
  endfunction

  // Rotate and shift group; bit 8 of the return is the carry out.
  function automatic logic [8:0] calc_rotate(logic [2:0] sel, logic [7:0] v, logic cin);
    case (sel)
      3'd0:    return {v[7], v[6:0], v[7]};
      3'd1:    return {v[0], v[0], v[7:1]};
      3'd2:    return {v[7], v[6:0], cin};
      3'd3:    return {v[0], cin, v[7:1]};
      3'd4:    return {v[7], v[6:0], 1'b0};
      3'd5:    return {v[0], v[7], v[7:1]};
      3'd6:    return {1'b0, v[3:0], v[7:4]};
      default: return {v[0], 1'b0, v[7:1]};
    endcase
  endfunction

  // Expected result word for one request word.
  function automatic alu_rsp_t calc_alu_word(alu_req_t w);
    alu_rsp_t   o;
    logic [2:0] y;
    logic [8:0] sh;
    logic [7:0] off;
    logic       c;
    logic [3:0] f;
    f  = w.flags_in;
    y  = w.opcode[5:3];
    o  = '{result: 8'h00, flags_out: f, write_enable: 1'b0, handled: 1'b0};
    if (w.req_type == PAGE_CB) begin
      o.handled = 1'b1;
      case (w.opcode[7:6])
        2'd0: begin
          sh = calc_rotate(y, w.operand, f[0]);
          o.result       = sh[7:0];
          o.flags_out    = {sh[7:0] == 8'h00, 1'b0, 1'b0, sh[8]};
          o.write_enable = 1'b1;
        end
        2'd1: o.flags_out = {~w.operand[y], 1'b0, 1'b1, f[0]};
        2'd2: begin
          o.result       = w.operand & ~(8'h01 << y);
          o.write_enable = 1'b1;
        end
        default: begin
          o.result       = w.operand | (8'h01 << y);
          o.write_enable = 1'b1;
        end
      endcase
    end else if ((w.opcode & 8'hc7) == 8'h04) begin
      o.result    = w.operand + 8'h01;
      o.flags_out = {o.result == 8'h00, 1'b0, w.operand[3:0] == 4'hf, f[0]};
      o.write_enable = 1'b1;
      o.handled      = 1'b1;
    end else if ((w.opcode & 8'hc7) == 8'h05) begin
      o.result    = w.operand - 8'h01;
      o.flags_out = {o.result == 8'h00, 1'b1, w.operand[3:0] == 4'h0, f[0]};
      o.write_enable = 1'b1;
      o.handled      = 1'b1;
    end else if ((w.opcode & 8'hc7) == 8'h07) begin
      o.write_enable = 1'b1;
      o.handled      = 1'b1;
      if (y < 3'd4) begin
        sh = calc_rotate(y, w.accum, f[0]);
        o.result    = sh[7:0];
        o.flags_out = {3'b000, sh[8]};
      end else if (y == 3'd4) begin
        // Decimal adjust: both decisions look at the incoming accumulator.
        off = 8'h00;
        c   = f[0];
        if (f[1] || (!f[2] && w.accum[3:0] > 4'h9)) off = off | 8'h06;
        if (f[0] || (!f[2] && w.accum > 8'h99)) begin
          off = off | 8'h60;
          c   = 1'b1;
        end
        o.result    = f[2] ? w.accum - off : w.accum + off;
        o.flags_out = {o.result == 8'h00, f[2], 1'b0, c};
      end else if (y == 3'd5) begin
        o.result    = ~w.accum;
        o.flags_out = {f[3], 1'b1, 1'b1, f[0]};
      end else if (y == 3'd6) begin
        o.result    = w.accum;
        o.flags_out = {f[3], 3'b001};
      end else begin
        o.result    = w.accum;
        o.flags_out = {f[3], 2'b00, ~f[0]};
      end
    end else if (w.opcode[7:6] == 2'b10 || (w.opcode & 8'hc7) == 8'hc6) begin
      o = calc_acc_op(y, w.accum, w.operand, f);
    end
    return o;
  endfunction

  function automatic alu_req_t rand_word(bit cb);
    alu_req_t w;
    w.req_type = cb ? PAGE_CB : PAGE_MAIN;
    w.opcode   = 8'($urandom);
    w.accum    = 8'($urandom);
    w.operand  = 8'($urandom);
    w.flags_in = 4'($urandom);
    // Bias the main page towards the ALU block and the accumulator group.
    if (!cb) begin
      case ($urandom_range(0, 3))
        0: w.opcode = {2'b10, w.opcode[5:0]};
        1: w.opcode = {2'b00, w.opcode[5:3], 3'b111};
        default: ;
      endcase
    end
    return w;
  endfunction

  // Request driver: offers the oldest pending word, with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid    <= 1'b0;
      req.req_type <= 1'b0;
      req.opcode   <= '0;
      req.accum    <= '0;
      req.operand  <= '0;
      req.flags_in <= '0;
      req_gap      <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_words.push_back(calc_alu_word({req.req_type, req.opcode, req.accum,
                                                req.operand, req.flags_in}));
      end
      if (!req.valid || req.ready) begin
        if (req_gap > 0) begin
          req.valid <= 1'b0;
          req_gap   <= req_gap - 1;
        end else if (pending_words.size() > 0) begin
          alu_req_t w;
          w = pending_words.pop_front();
          {req.req_type, req.opcode, req.accum, req.operand, req.flags_in} <= w;
          req.valid <= 1'b1;
          if (!quiet_phase && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 15);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted word and applies random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      rsp_gap   <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        alu_rsp_t got;
        alu_rsp_t exp_w;
        got = {rsp.result, rsp.flags_out, rsp.write_enable, rsp.handled};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_w = expected_words.pop_front();
          words_checked++;
          if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp res=%h f=%h we=%b hd=%b, got res=%h f=%h we=%b hd=%b",
                       exp_w.result, exp_w.flags_out, exp_w.write_enable, exp_w.handled,
                       got.result, got.flags_out, got.write_enable, got.handled);
          end
        end
      end
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp.ready <= 1'b0;
        rsp_gap   <= rsp_gap - 1;
      end else begin
        rsp.ready <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 9) == 0) rsp_gap <= $urandom_range(1, 15);
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering words.
  initial begin
    hold_rsp = 1'b0;
    wait (words_checked >= 100);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (60) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    alu_req_t w;
    int       drain;
    mismatches    = 0;
    words_checked = 0;
    cb_words      = 0;
    quiet_phase   = 1'b0;
    rst_ni        = 1'b0;
    // Directed: field extremes, special cases and at least one word per operation group.
    pending_words.push_back('{PAGE_MAIN, OP_ADD_B, 8'hff, 8'h01, 4'h0});
    pending_words.push_back('{PAGE_MAIN, 8'h8f,    8'hff, 8'hff, 4'hf});
    pending_words.push_back('{PAGE_MAIN, 8'h9f,    8'h00, 8'hff, 4'hf});
    pending_words.push_back('{PAGE_MAIN, OP_CP_N,  8'h3c, 8'h3c, 4'h0});
    pending_words.push_back('{PAGE_MAIN, 8'hbf,    8'h00, 8'h01, 4'h0});
    pending_words.push_back('{PAGE_MAIN, 8'ha7,    8'hf0, 8'h0f, 4'h0});
    pending_words.push_back('{PAGE_MAIN, 8'hae,    8'haa, 8'h55, 4'h0});
    pending_words.push_back('{PAGE_MAIN, 8'hf6,    8'h00, 8'h00, 4'hf});
    pending_words.push_back('{PAGE_MAIN, 8'h3c,    8'h00, 8'hff, 4'h1});
    pending_words.push_back('{PAGE_MAIN, 8'h05,    8'h00, 8'h10, 4'h0});
    pending_words.push_back('{PAGE_MAIN, 8'h3d,    8'h00, 8'h01, 4'h0});
    pending_words.push_back('{PAGE_MAIN, OP_DAA,   8'h9a, 8'h00, 4'h0});
    pending_words.push_back('{PAGE_MAIN, OP_DAA,   8'h00, 8'h00, 4'h7});
    pending_words.push_back('{PAGE_MAIN, OP_DAA,   8'h45, 8'h00, 4'h4});
    pending_words.push_back('{PAGE_MAIN, OP_CPL,   8'h5a, 8'h00, 4'h8});
    pending_words.push_back('{PAGE_MAIN, OP_SCF,   8'h12, 8'h00, 4'h8});
    pending_words.push_back('{PAGE_MAIN, OP_CCF,   8'h12, 8'h00, 4'h9});
    pending_words.push_back('{PAGE_MAIN, 8'h17,    8'h80, 8'h00, 4'h0});
    pending_words.push_back('{PAGE_MAIN, 8'h1f,    8'h01, 8'h00, 4'h1});
    pending_words.push_back('{PAGE_MAIN, OP_NOP,   8'h12, 8'h34, 4'h5});
    pending_words.push_back('{PAGE_CB,   8'h37,    8'h00, 8'h00, 4'h0});
    pending_words.push_back('{PAGE_CB,   8'h7f,    8'h00, 8'h80, 4'h0});
    pending_words.push_back('{PAGE_CB,   8'h47,    8'hff, 8'hfe, 4'h1});
    pending_words.push_back('{PAGE_CB,   8'hbf,    8'h00, 8'hff, 4'h0});
    pending_words.push_back('{PAGE_CB,   8'hc0,    8'h00, 8'h00, 4'h0});
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 700; i++) begin
      w = rand_word($urandom_range(0, 3) == 0);
      if (w.req_type == PAGE_CB) cb_words++;
      pending_words.push_back(w);
    end
    wait (pending_words.size() < 120);
    quiet_phase = 1'b1;
    wait (pending_words.size() == 0 && !(req.valid && !req.ready));
    @(posedge clk_i);
    drain = 0;
    while (expected_words.size() > 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_words.size() > 0) mismatches++;
    $display("Checked %0d result words from 725 requests, %0d random CB-page words,",
             words_checked, cb_words);
    $display("with random stalls on both channels and one long result hold-off.");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
src/sm83_pkg.sv
src/sm83_if.sv
src/sm83_front.sv
src/sm83_queue.sv
src/sm83_back.sv
src/sm83_alu_with_flags_unit.sv
dv/tb_sm83_alu_with_flags_unit.sv
